FILE: src/brio_hilbert_sort_key_assert.svh
// Assertion macros shared by the sort key block.
`ifndef BRIO_HILBERT_SORT_KEY_ASSERT_SVH
`define BRIO_HILBERT_SORT_KEY_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define HSK_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define HSK_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define HSK_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hsk_pkg.sv
// Shared constants and types for the sort key block.
`timescale 1ns / 1ps
package hsk_pkg;

    localparam int COORD_BITS_DEF = 20;
    localparam int MAX_ROUND_DEF  = 31;

    localparam int ID_W        = 24;
    localparam int GRID_W      = 20;
    localparam int ROUND_W     = 5;
    localparam int HILBERT_W   = 60;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 96;

    // Items allowed between input and output at once.
    localparam int INFLIGHT_MAX = 8;

    localparam logic [63:0] GOLDEN_INC = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_MUL_A  = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_MUL_B  = 64'h94D049BB133111EB;

    typedef enum logic {
        RND_IDLE,
        RND_DRAW
    } rnd_state_t;

    // Control travelling with a point down the key chain.
    typedef struct packed {
        logic            valid;
        logic [ID_W-1:0] id;
    } cell_ctl_t;

    // One finished generator draw.
    typedef struct packed {
        logic        valid;
        logic        odd;
        logic [63:0] state;
    } draw_res_t;

endpackage

FILE: src/hsk_level_cell.sv
// One bit level of the Hilbert transpose: conditional invert or exchange of low bits.
`timescale 1ns / 1ps
module hsk_level_cell #(
    parameter int COORD_BITS = hsk_pkg::COORD_BITS_DEF,
    parameter int LEVEL      = 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  hsk_pkg::cell_ctl_t    ctl_in,
    input  logic [COORD_BITS-1:0] w0_in,
    input  logic [COORD_BITS-1:0] w1_in,
    input  logic [COORD_BITS-1:0] w2_in,
    output hsk_pkg::cell_ctl_t    ctl_out,
    output logic [COORD_BITS-1:0] w0_out,
    output logic [COORD_BITS-1:0] w1_out,
    output logic [COORD_BITS-1:0] w2_out
);
    import hsk_pkg::*;

    localparam logic [COORD_BITS-1:0] LOW_MASK =
        (COORD_BITS'(1) << LEVEL) - COORD_BITS'(1);

    cell_ctl_t             ctl_reg;
    logic [COORD_BITS-1:0] w0_reg, w1_reg, w2_reg;
    logic [COORD_BITS-1:0] w0_next, w1_next, w2_next;
    logic [COORD_BITS-1:0] t1, t2;

    always_comb begin
        w0_next = w0_in;
        w1_next = w1_in;
        w2_next = w2_in;
        t1      = '0;
        t2      = '0;
        if (w0_next[LEVEL]) begin
            w0_next = w0_next ^ LOW_MASK;
        end
        if (w1_next[LEVEL]) begin
            w0_next = w0_next ^ LOW_MASK;
        end else begin
            t1      = (w0_next ^ w1_next) & LOW_MASK;
            w0_next = w0_next ^ t1;
            w1_next = w1_next ^ t1;
        end
        if (w2_next[LEVEL]) begin
            w0_next = w0_next ^ LOW_MASK;
        end else begin
            t2      = (w0_next ^ w2_next) & LOW_MASK;
            w0_next = w0_next ^ t2;
            w2_next = w2_next ^ t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (adv) begin
            ctl_reg.valid <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg.id <= ctl_in.id;
            w0_reg     <= w0_next;
            w1_reg     <= w1_next;
            w2_reg     <= w2_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign w0_out  = w0_reg;
    assign w1_out  = w1_reg;
    assign w2_out  = w2_reg;

endmodule

FILE: src/hsk_gray_cell.sv
// Last cell of the key chain: Gray decode of the transpose and bit interleave.
`timescale 1ns / 1ps
module hsk_gray_cell #(
    parameter int COORD_BITS = hsk_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  hsk_pkg::cell_ctl_t            ctl_in,
    input  logic [COORD_BITS-1:0]         w0_in,
    input  logic [COORD_BITS-1:0]         w1_in,
    input  logic [COORD_BITS-1:0]         w2_in,
    output hsk_pkg::cell_ctl_t            ctl_out,
    output logic [hsk_pkg::HILBERT_W-1:0] key_out
);
    import hsk_pkg::*;

    cell_ctl_t             ctl_reg;
    logic [HILBERT_W-1:0]  key_reg;
    logic [HILBERT_W-1:0]  key_next;
    logic [COORD_BITS-1:0] g0, g1, g2, tmask;

    always_comb begin
        g0 = w0_in;
        g1 = w1_in ^ g0;
        g2 = w2_in ^ g1;
        // each low bit flips with the parity of all higher bits of the last word
        for (int j = 0; j < COORD_BITS; j++) begin
            tmask[j] = ^(g2 >> (j + 1));
        end
        g0 = g0 ^ tmask;
        g1 = g1 ^ tmask;
        g2 = g2 ^ tmask;
        key_next = '0;
        for (int b = 0; b < COORD_BITS; b++) begin
            if (3 * b + 2 < HILBERT_W) begin
                key_next[3 * b + 2] = g0[b];
            end
            if (3 * b + 1 < HILBERT_W) begin
                key_next[3 * b + 1] = g1[b];
            end
            if (3 * b < HILBERT_W) begin
                key_next[3 * b] = g2[b];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.valid <= 1'b0;
        end else if (adv) begin
            ctl_reg.valid <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg.id <= ctl_in.id;
            key_reg    <= key_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign key_out = key_reg;

endmodule

FILE: src/hsk_mix_pipe.sv
// Four-stage splitmix64 output pipeline; reports the low bit of each draw.
`timescale 1ns / 1ps
module hsk_mix_pipe (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               flush,
    input  logic               issue_valid,
    input  logic [63:0]        issue_state,
    output hsk_pkg::draw_res_t res
);
    import hsk_pkg::*;

    logic        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [63:0] s1_reg, s2_reg, s3_reg, s4_reg;
    logic [63:0] z1_reg;
    logic [63:0] p0_reg, p0_next;
    logic [31:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [31:0] y3_reg;
    logic [63:0] prod_a, y_a;
    logic [31:0] q_b;
    logic        odd4_reg;

    always_comb begin
        p0_next = z1_reg[31:0] * MIX_MUL_A[31:0];
        p1_next = z1_reg[31:0] * MIX_MUL_A[63:32];
        p2_next = z1_reg[63:32] * MIX_MUL_A[31:0];
        prod_a  = p0_reg + {p1_reg + p2_reg, 32'd0};
        y_a     = prod_a ^ (prod_a >> 27);
        // only the low 32 bits of the second product reach bit 0 of the draw
        q_b     = y3_reg * MIX_MUL_B[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || flush) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= issue_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_reg   <= issue_state;
        z1_reg   <= issue_state ^ (issue_state >> 30);
        s2_reg   <= s1_reg;
        p0_reg   <= p0_next;
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        s3_reg   <= s2_reg;
        y3_reg   <= y_a[31:0];
        s4_reg   <= s3_reg;
        odd4_reg <= q_b[0] ^ q_b[31];
    end

    assign res.valid = v4_reg;
    assign res.odd   = odd4_reg;
    assign res.state = s4_reg;

endmodule

FILE: src/brio_hilbert_sort_key.sv
// Top level of the BRIO round and 3-D Hilbert sort key generator.
//
// Usage: points arrive on the s_ stream, one per beat; each produces exactly one
// beat on the m_ stream, in input order. cfg_wen/cfg_wdata load the generator
// seed (zero acts as one) and restart the round sequence; write only when idle.
// The key runs down a chain of COORD_BITS cells, one bit level per cell but the
// last, which does the Gray decode; one cell per cycle unless the chain stalls.
// The round comes from a four-stage draw pipeline fed with a new draw every
// cycle while drawing; once a draw settles the round the later draws are dropped
// and the generator state rewinds to the settling draw. A new point is taken only
// once the round unit is idle, its last round settled after 1 to MAX_ROUND + 1
// draws. An output beat is registered once a point and its queued round meet.
// Up to INFLIGHT_MAX points may be between input and output.
// Reset: aresetn low for one clock empties the block and sets the seed to one.
// Stall: the output register holds its beat while m_tready is low; the key chain
// then stops as a whole once its last cell holds a point, which drops s_tready.
`timescale 1ns / 1ps
`include "brio_hilbert_sort_key_assert.svh"
module brio_hilbert_sort_key #(
    parameter int COORD_BITS = hsk_pkg::COORD_BITS_DEF,
    parameter int MAX_ROUND  = hsk_pkg::MAX_ROUND_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wen,
    input  logic [63:0]                     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // point_id[23:0], x_grid[43:24], y_grid[63:44], z_grid[83:64], zero pad
    input  logic [hsk_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // point_id_out[23:0], brio_round[28:24], hilbert_index[88:29], zero pad
    output logic [hsk_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import hsk_pkg::*;

    localparam int RW     = $clog2(MAX_ROUND + 1);
    localparam int INF_W  = $clog2(INFLIGHT_MAX + 1);
    localparam int PTR_W  = $clog2(INFLIGHT_MAX);
    localparam int PAD_W  = OUT_TDATA_W - ID_W - ROUND_W - HILBERT_W;

    // Key chain
    cell_ctl_t             ctl_c [COORD_BITS];
    logic [COORD_BITS-1:0] w0_c  [COORD_BITS];
    logic [COORD_BITS-1:0] w1_c  [COORD_BITS];
    logic [COORD_BITS-1:0] w2_c  [COORD_BITS];
    cell_ctl_t             tail_ctl;
    logic [HILBERT_W-1:0]  tail_key;
    logic [GRID_W:0]       x_ext, y_ext, z_ext;
    logic                  adv;
    logic                  in_accept;
    logic                  join_fire;

    // Round unit
    rnd_state_t            rnd_state_reg, rnd_state_next;
    logic [RW-1:0]         round_reg, round_next;
    logic [63:0]           prng_reg, prng_next;
    logic [63:0]           issue_state_reg, issue_state_next;
    logic [63:0]           issue_value;
    logic                  issue_valid, flush, push;
    draw_res_t             draw_res;
    logic [RW+ROUND_W-1:0] round_wide;

    // Round queue and in-flight count
    logic [ROUND_W-1:0]    rnd_fifo_reg [INFLIGHT_MAX];
    logic [PTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [INF_W-1:0]      fifo_cnt_reg, fifo_cnt_next;
    logic [INF_W-1:0]      inflight_reg, inflight_next;

    // Output register
    logic                  m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;

    // Input side
    assign x_ext = {1'b0, s_tdata[ID_W +: GRID_W]};
    assign y_ext = {1'b0, s_tdata[ID_W + GRID_W +: GRID_W]};
    assign z_ext = {1'b0, s_tdata[ID_W + 2 * GRID_W +: GRID_W]};

    assign join_fire = tail_ctl.valid && (fifo_cnt_reg != '0) && (!m_tvalid_reg || m_tready);
    assign adv       = !tail_ctl.valid || join_fire;
    assign s_tready  = (rnd_state_reg == RND_IDLE) && (inflight_reg < INF_W'(INFLIGHT_MAX))
                       && adv;
    assign in_accept = s_tvalid && s_tready;

    assign ctl_c[0].valid = in_accept;
    assign ctl_c[0].id    = s_tdata[ID_W-1:0];
    assign w0_c[0]        = x_ext[COORD_BITS-1:0];
    assign w1_c[0]        = y_ext[COORD_BITS-1:0];
    assign w2_c[0]        = z_ext[COORD_BITS-1:0];

    for (genvar k = 0; k < COORD_BITS - 1; k++) begin : g_cell
        hsk_level_cell #(
            .COORD_BITS (COORD_BITS),
            .LEVEL      (COORD_BITS - 1 - k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .ctl_in  (ctl_c[k]),
            .w0_in   (w0_c[k]),
            .w1_in   (w1_c[k]),
            .w2_in   (w2_c[k]),
            .ctl_out (ctl_c[k+1]),
            .w0_out  (w0_c[k+1]),
            .w1_out  (w1_c[k+1]),
            .w2_out  (w2_c[k+1])
        );
    end

    hsk_gray_cell #(
        .COORD_BITS (COORD_BITS)
    ) u_gray (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .ctl_in  (ctl_c[COORD_BITS-1]),
        .w0_in   (w0_c[COORD_BITS-1]),
        .w1_in   (w1_c[COORD_BITS-1]),
        .w2_in   (w2_c[COORD_BITS-1]),
        .ctl_out (tail_ctl),
        .key_out (tail_key)
    );

    // Round unit
    assign issue_value = issue_state_reg + GOLDEN_INC;

    hsk_mix_pipe u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .flush       (flush),
        .issue_valid (issue_valid),
        .issue_state (issue_value),
        .res         (draw_res)
    );

    always_comb begin
        rnd_state_next   = rnd_state_reg;
        round_next       = round_reg;
        issue_state_next = issue_state_reg;
        prng_next        = prng_reg;
        issue_valid      = 1'b0;
        flush            = 1'b0;
        push             = 1'b0;
        unique case (rnd_state_reg)
            RND_IDLE: begin
                if (in_accept) begin
                    rnd_state_next   = RND_DRAW;
                    round_next       = '0;
                    issue_state_next = prng_reg;
                end
            end
            RND_DRAW: begin
                // keep drawing ahead; surplus draws are dropped at the end
                issue_valid      = 1'b1;
                issue_state_next = issue_value;
                if (draw_res.valid) begin
                    if (draw_res.odd && (round_reg < RW'(MAX_ROUND))) begin
                        round_next = round_reg + RW'(1);
                    end else begin
                        push           = 1'b1;
                        flush          = 1'b1;
                        prng_next      = draw_res.state;
                        rnd_state_next = RND_IDLE;
                    end
                end
            end
            default: begin
                rnd_state_next = RND_IDLE;
            end
        endcase
        if (cfg_wen) begin
            prng_next = (cfg_wdata == 64'd0) ? 64'd1 : cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_state_reg <= RND_IDLE;
            prng_reg      <= 64'd1;
        end else begin
            rnd_state_reg <= rnd_state_next;
            prng_reg      <= prng_next;
        end
    end

    always_ff @(posedge aclk) begin
        round_reg       <= round_next;
        issue_state_reg <= issue_state_next;
    end

    // Round queue
    assign round_wide = {{ROUND_W{1'b0}}, round_reg};

    always_comb begin
        fifo_cnt_next = fifo_cnt_reg;
        inflight_next = inflight_reg;
        if (push && !join_fire) begin
            fifo_cnt_next = fifo_cnt_reg + INF_W'(1);
        end else if (!push && join_fire) begin
            fifo_cnt_next = fifo_cnt_reg - INF_W'(1);
        end
        if (in_accept && !join_fire) begin
            inflight_next = inflight_reg + INF_W'(1);
        end else if (!in_accept && join_fire) begin
            inflight_next = inflight_reg - INF_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            fifo_cnt_reg <= '0;
            inflight_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (join_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fifo_cnt_reg <= fifo_cnt_next;
            inflight_reg <= inflight_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            rnd_fifo_reg[wr_ptr_reg] <= round_wide[ROUND_W-1:0];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (join_fire) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (join_fire) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, tail_key, rnd_fifo_reg[rd_ptr_reg], tail_ctl.id};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `HSK_ASSERT_ALWAYS(a_inflight_cap, aclk, aresetn,
        inflight_reg <= INF_W'(INFLIGHT_MAX), "in-flight count above its limit")
    `HSK_ASSERT_ALWAYS(a_rounds_le_inflight, aclk, aresetn,
        fifo_cnt_reg <= inflight_reg, "more queued rounds than points in flight")
    `HSK_ASSERT_IMPL(a_idle_no_draw, aclk, aresetn,
        rnd_state_reg == RND_IDLE, !draw_res.valid, "stale draw reached idle round unit")
    `HSK_ASSERT_NEXT(a_accept_draws, aclk, aresetn,
        in_accept, rnd_state_reg == RND_DRAW, "accepted point did not start drawing")
    `HSK_ASSERT_NEXT(a_join_shows, aclk, aresetn,
        join_fire, m_tvalid_reg, "joined result not presented")

endmodule
